### hdl/wrip_pkg.sv
// Shared types and constants for the weighted random index picker.
`default_nettype none

package wrip_pkg;

    localparam int CMD_W    = 2;
    localparam int PICKED_W = 10;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;        // append weight to prefix table
        logic clear;       // empty the table
        logic pick_start;  // latch random value, reset remainder
        logic div_step;    // one restoring-division bit
        logic srch_init;   // lo = 0, hi = count, goal = rem + 1
        logic srch_read;   // read prefix sum at mid
        logic srch_cmp;    // narrow [lo, hi) using the read value
        logic emit;        // load result payload
        logic emit_err;    // result payload is the empty-table status
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic empty;       // no entries or zero total
        logic div_last;    // current division step is the last one
        logic srch_done;   // lo has met hi
    } t_dp_sts;

endpackage

`default_nettype wire

### hdl/wrip_if.sv
// Input and result channel interfaces for the weighted random index picker.
`default_nettype none

interface wrip_in_if #(
    parameter int WEIGHT_BITS = 16,
    parameter int RANDOM_BITS = 32
);
    import wrip_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [WEIGHT_BITS-1:0] weight_value;
    logic [RANDOM_BITS-1:0] random_value;

    modport source (output valid, command, weight_value, random_value, input ready);
    modport sink   (input valid, command, weight_value, random_value, output ready);
endinterface

interface wrip_out_if;
    import wrip_pkg::*;

    logic                valid;
    logic                ready;
    logic [PICKED_W-1:0] picked_index;
    logic                status;
    logic                overflow_seen;

    modport source (output valid, picked_index, status, overflow_seen, input ready);
    modport sink   (input valid, picked_index, status, overflow_seen, output ready);
endinterface

`default_nettype wire

### hdl/wrip_dp.sv
// Datapath: prefix-sum memory, bit-serial modulo and binary search registers.
`default_nettype none

module wrip_dp #(
    parameter int MAX_ENTRIES = 1024,
    parameter int WEIGHT_BITS = 16,
    parameter int RANDOM_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire wrip_pkg::t_dp_cmd            i_cmd,
    output wrip_pkg::t_dp_sts                 o_sts,
    input  wire logic [WEIGHT_BITS-1:0]       i_weight_value,
    input  wire logic [RANDOM_BITS-1:0]       i_random_value,
    output logic [wrip_pkg::PICKED_W-1:0]     o_picked_index,
    output logic                              o_status,
    output logic                              o_overflow_seen
);
    import wrip_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W = WEIGHT_BITS + IDX_W;
    localparam int BIT_W = (RANDOM_BITS > 1) ? $clog2(RANDOM_BITS) : 1;
    localparam int EXT_W = (IDX_W > PICKED_W) ? IDX_W : PICKED_W;

    logic [SUM_W-1:0]       r_mem [MAX_ENTRIES];
    logic [CNT_W-1:0]       r_count;
    logic [SUM_W-1:0]       r_total;
    logic                   r_overflow;

    logic [RANDOM_BITS-1:0] r_rnd;
    logic [SUM_W-1:0]       r_rem;
    logic [BIT_W-1:0]       r_bit_cnt;

    logic [SUM_W:0]         r_goal;
    logic [CNT_W-1:0]       r_lo;
    logic [CNT_W-1:0]       r_hi;
    logic [CNT_W-1:0]       r_mid;
    logic [SUM_W-1:0]       r_rd_data;

    logic [SUM_W-1:0]       w_total_next;
    logic [SUM_W:0]         w_rem_sh;
    logic [SUM_W:0]         w_rem_sub;
    logic [CNT_W:0]         w_lohi;
    logic [CNT_W-1:0]       w_mid;
    logic [EXT_W-1:0]       w_idx_ext;
    logic                   w_full;

    assign w_full       = (r_count == CNT_W'(MAX_ENTRIES));
    assign w_total_next = r_total + SUM_W'(i_weight_value);
    assign w_rem_sh     = {r_rem, r_rnd[RANDOM_BITS-1]};
    assign w_rem_sub    = w_rem_sh - {1'b0, r_total};
    assign w_lohi       = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid        = w_lohi[CNT_W:1];
    assign w_idx_ext    = EXT_W'(r_lo[IDX_W-1:0]);

    assign o_sts.empty     = (r_count == '0) || (r_total == '0);
    assign o_sts.div_last  = (r_bit_cnt == '0);
    assign o_sts.srch_done = (r_lo >= r_hi);

    // Table bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_total    <= '0;
            r_overflow <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_total <= '0;
        end else if (i_cmd.load) begin
            if (w_full) begin
                r_overflow <= 1'b1;
            end else begin
                r_count <= r_count + CNT_W'(1);
                r_total <= w_total_next;
            end
        end
    end

    // Prefix-sum memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            r_mem[r_count[IDX_W-1:0]] <= w_total_next;
        end
        if (i_cmd.srch_read) begin
            r_rd_data <= r_mem[w_mid[IDX_W-1:0]];
        end
    end

    // Restoring division, one random bit per step, remainder only
    always_ff @(posedge i_clk) begin
        if (i_cmd.pick_start) begin
            r_rnd     <= i_random_value;
            r_rem     <= '0;
            r_bit_cnt <= BIT_W'(RANDOM_BITS - 1);
        end else if (i_cmd.div_step) begin
            r_rnd     <= r_rnd << 1;
            r_bit_cnt <= r_bit_cnt - BIT_W'(1);
            if (w_rem_sh >= {1'b0, r_total}) begin
                r_rem <= w_rem_sub[SUM_W-1:0];
            end else begin
                r_rem <= w_rem_sh[SUM_W-1:0];
            end
        end
    end

    // Leftmost search over [lo, hi)
    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            r_goal <= {1'b0, r_rem} + (SUM_W+1)'(1);
            r_lo   <= '0;
            r_hi   <= r_count;
        end else if (i_cmd.srch_read) begin
            r_mid <= w_mid;
        end else if (i_cmd.srch_cmp) begin
            if ({1'b0, r_rd_data} < r_goal) begin
                r_lo <= r_mid + CNT_W'(1);
            end else begin
                r_hi <= r_mid;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_overflow_seen <= r_overflow;
            if (i_cmd.emit_err) begin
                o_picked_index <= '0;
                o_status       <= STATUS_EMPTY;
            end else begin
                o_picked_index <= w_idx_ext[PICKED_W-1:0];
                o_status       <= STATUS_OK;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/wrip_ctrl.sv
// Controller: sequences load, clear and pick through the datapath.
`default_nettype none

module wrip_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic [wrip_pkg::CMD_W-1:0]   i_command,
    output logic                              o_in_ready,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output wrip_pkg::t_dp_cmd                 o_cmd,
    input  wire wrip_pkg::t_dp_sts            i_sts
);
    import wrip_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SINIT,
        S_SREQ,
        S_SCMP,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_err;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_command)
                        CMD_LOAD:  o_cmd.load  = 1'b1;
                        CMD_CLEAR: o_cmd.clear = 1'b1;
                        CMD_PICK: begin
                            o_cmd.pick_start = 1'b1;
                            n_state = i_sts.empty ? S_EMIT : S_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_SINIT;
                end
            end
            S_SINIT: begin
                o_cmd.srch_init = 1'b1;
                n_state = S_SREQ;
            end
            S_SREQ: begin
                if (i_sts.srch_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.srch_read = 1'b1;
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd.srch_cmp = 1'b1;
                n_state = S_SREQ;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_err = r_err;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_err       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.pick_start) begin
                r_err <= i_sts.empty;
            end
            if (o_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/weighted_random_index_picker.sv
// Load and clear take effect in the cycle of acceptance.
// Pick: a one-bit-per-cycle modulo of the random value by the total weight, then a binary
// search over the prefix sums in which each step is a memory read followed by a compare.
// Pick on an empty or zero-weight table skips the modulo and search and returns the empty status.
// One item in flight; the next is taken while a result waits in the output register.
// Synchronous active-low reset empties the table and clears the overflow flag.
`default_nettype none

module weighted_random_index_picker #(
    parameter int MAX_ENTRIES = 1024,
    parameter int WEIGHT_BITS = 16,
    parameter int RANDOM_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wrip_in_if.sink   i_cmd,
    wrip_out_if.source o_res
);
    import wrip_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    wrip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_command   (i_cmd.command),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    wrip_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .RANDOM_BITS (RANDOM_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_weight_value  (i_cmd.weight_value),
        .i_random_value  (i_cmd.random_value),
        .o_picked_index  (o_res.picked_index),
        .o_status        (o_res.status),
        .o_overflow_seen (o_res.overflow_seen)
    );

endmodule

`default_nettype wire
